// ===== hdl/hhsp_pkg.sv =====
// types, span kind codes and parse phases for the http head span parser
// no dependencies; imported by http_head_span_parser_core
package hhsp_pkg;

   // span kinds carried on the result channel
   localparam logic [3:0] KIND_METHOD     = 4'd0;
   localparam logic [3:0] KIND_URI        = 4'd1;
   localparam logic [3:0] KIND_QUERY      = 4'd2;
   localparam logic [3:0] KIND_PROTO      = 4'd3;
   localparam logic [3:0] KIND_CODE       = 4'd4;
   localparam logic [3:0] KIND_REASON     = 4'd5;
   localparam logic [3:0] KIND_NAME       = 4'd6;
   localparam logic [3:0] KIND_VALUE      = 4'd7;
   localparam logic [3:0] KIND_HEAD       = 4'd8;
   localparam logic [3:0] KIND_MSG        = 4'd9;
   localparam logic [3:0] KIND_ERR        = 4'd10;
   localparam logic [3:0] KIND_INCOMPLETE = 4'd11;

   localparam logic [3:0] LEN_NAME_SIZE = 4'd14;
   localparam int         MAX_RES       = 3;

   typedef enum logic [4:0] {
      PH_WS, PH_METHOD, PH_METHOD_SP, PH_URI, PH_QUERY, PH_URI_SP, PH_PROTO,
      PH_RPROTO, PH_RPROTO_SP, PH_CODE1, PH_CODE2, PH_CODE_SP, PH_REASON,
      PH_LINE_NL, PH_NAME, PH_NAME_DELIM, PH_VALUE, PH_IGNORE, PH_BODY, PH_ERROR
   } phase_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [31:0] num;
      logic        last;
   } result_type;

   // results of one byte, in order, with their count
   typedef struct packed {
      result_type [MAX_RES-1:0] item;
      logic [1:0]               count;
   } res_list_type;

   // lower-case "content-length"
   function automatic logic [7:0] len_name_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "c";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "l";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic result_type mk_res(input logic [3:0] kind,
                                         input logic [15:0] start,
                                         input logic [15:0] length,
                                         input logic [31:0] num);
      result_type r;
      r.kind   = kind;
      r.start  = start;
      r.length = length;
      r.num    = num;
      r.last   = 1'b0;
      return r;
   endfunction

   // append a result, dropping anything past the third
   function automatic res_list_type add_res(input res_list_type lst,
                                            input result_type r);
      res_list_type o;
      o = lst;
      if (lst.count != 2'(MAX_RES)) begin
         o.item[lst.count] = r;
         o.count           = lst.count + 2'd1;
      end
      return o;
   endfunction

   function automatic logic [15:0] sat16_32(input logic [31:0] v);
      return (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [15:0] sat16_17(input logic [16:0] v);
      return v[16] ? 16'hFFFF : v[15:0];
   endfunction

endpackage

// ===== hdl/http_head_span_parser_core.sv =====
// A byte's results are written into a 4-entry result queue at the accepting edge and
// leave it in order, one per cycle while rsp_tready is high.
// Throughput: one byte per cycle while rsp_tready is high and each byte gives at most
// one result; the queue must hold room for three results for a byte to be taken. The
// parse state updates in one pass. Reset (synchronous, active high) returns to the
// leading whitespace phase, empties the queue and sets is_request to 1.
// depends on hhsp_pkg
module http_head_span_parser_core import hhsp_pkg::*; #(
   parameter int MAX_HEADERS = 64,
   parameter int MAX_MESSAGE = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] span_kind, [19:4] span_start,
                                    // [35:20] span_length, [67:36] numeric_value
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // is_request
);

   localparam logic [16:0] LastOff  = 17'(MAX_MESSAGE - 1);
   localparam logic [6:0]  HdrLimit = 7'(MAX_HEADERS - 1);

   // parse state
   logic        isreq_ff;
   phase_type   phase_ff, phase_in;
   logic [15:0] off_ff, off_in;
   logic [15:0] fstart_ff, fstart_in;
   logic [15:0] lastns_ff, lastns_in;
   logic [6:0]  hcnt_ff, hcnt_in;
   logic [3:0]  midx_ff, midx_in;
   logic        match_ff, match_in;
   logic        seen_ff, seen_in;
   logic [31:0] lacc_ff, lacc_in;
   logic [9:0]  cacc_ff, cacc_in;
   logic [1:0]  term_ff, term_in;
   logic [16:0] hlen_ff, hlen_in;

   res_list_type res;
   logic         req_fire;

   // result queue
   result_type  fifo_ff [4];
   logic [1:0]  rd_ff, wr_ff;
   logic [2:0]  cnt_ff;
   logic        pop;

   assign csr_ready  = 1'b1;
   assign req_tready = (cnt_ff <= 3'd1);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = {4'd0, fifo_ff[rd_ff].num, fifo_ff[rd_ff].length,
                        fifo_ff[rd_ff].start, fifo_ff[rd_ff].kind};
   assign rsp_tlast  = fifo_ff[rd_ff].last;

   // one byte through the parser
   always_comb begin
      logic [7:0]  b;
      logic [7:0]  lc;
      logic [16:0] pos1;
      logic        nl, digit, finished, head_end, chosen;
      logic [35:0] prod;
      b         = req_tdata;
      pos1      = {1'b0, off_ff} + 17'd1;
      nl        = (b == 8'h0D) || (b == 8'h0A);
      digit     = (b >= "0") && (b <= "9");
      lc        = ((b >= "A") && (b <= "Z")) ? (b + 8'd32) : b;
      finished  = 1'b0;
      head_end  = 1'b0;
      chosen    = 1'b0;
      prod      = 36'd0;
      res       = '0;
      phase_in  = phase_ff;
      off_in    = off_ff;
      fstart_in = fstart_ff;
      lastns_in = lastns_ff;
      hcnt_in   = hcnt_ff;
      midx_in   = midx_ff;
      match_in  = match_ff;
      seen_in   = seen_ff;
      lacc_in   = lacc_ff;
      cacc_in   = cacc_ff;
      term_in   = term_ff;
      hlen_in   = hlen_ff;

      if (phase_ff != PH_ERROR) begin
         if (phase_ff != PH_BODY) begin
            // control bytes are fatal in the head
            if (((b < 8'h20) && !nl) || (b == 8'h7F)) begin
               phase_in = PH_ERROR;
               res = add_res(res, mk_res(KIND_ERR, off_ff, 16'd0, 32'd0));
            end else begin
               unique case (phase_ff)
                  PH_WS: begin
                     if (!(b == " " || nl)) begin
                        fstart_in = off_ff;
                        phase_in  = isreq_ff ? PH_METHOD : PH_RPROTO;
                     end
                  end
                  PH_METHOD: begin
                     if (b == " ") begin
                        res = add_res(res, mk_res(KIND_METHOD, fstart_ff,
                                                  off_ff - fstart_ff, 32'd0));
                        phase_in = PH_METHOD_SP;
                     end
                  end
                  PH_METHOD_SP: begin
                     if (b == "?") begin
                        res = add_res(res, mk_res(KIND_URI, off_ff, 16'd0, 32'd0));
                        fstart_in = pos1[15:0];
                        phase_in  = PH_QUERY;
                     end else if (b != " ") begin
                        fstart_in = off_ff;
                        phase_in  = PH_URI;
                     end
                  end
                  PH_URI: begin
                     if (b == " " || b == "?") begin
                        res = add_res(res, mk_res(KIND_URI, fstart_ff,
                                                  off_ff - fstart_ff, 32'd0));
                        if (b == " ") begin
                           phase_in = PH_URI_SP;
                        end else begin
                           fstart_in = pos1[15:0];
                           phase_in  = PH_QUERY;
                        end
                     end
                  end
                  PH_QUERY: begin
                     if (b == " ") begin
                        res = add_res(res, mk_res(KIND_QUERY, fstart_ff,
                                                  off_ff - fstart_ff, 32'd0));
                        phase_in = PH_URI_SP;
                     end
                  end
                  PH_URI_SP: begin
                     if (nl) begin
                        res = add_res(res, mk_res(KIND_PROTO, off_ff, 16'd0, 32'd0));
                        phase_in = PH_LINE_NL;
                     end else if (b != " ") begin
                        fstart_in = off_ff;
                        phase_in  = PH_PROTO;
                     end
                  end
                  PH_PROTO, PH_REASON: begin
                     if (nl) begin
                        res = add_res(res, mk_res((phase_ff == PH_PROTO) ? KIND_PROTO
                                                                         : KIND_REASON,
                                                  fstart_ff, off_ff - fstart_ff, 32'd0));
                        phase_in = PH_LINE_NL;
                     end
                  end
                  PH_RPROTO: begin
                     if (b == " ") begin
                        res = add_res(res, mk_res(KIND_PROTO, fstart_ff,
                                                  off_ff - fstart_ff, 32'd0));
                        phase_in = PH_RPROTO_SP;
                     end
                  end
                  PH_RPROTO_SP: begin
                     if (b != " ") begin
                        if (!digit) begin
                           phase_in = PH_ERROR;
                           res = add_res(res, mk_res(KIND_ERR, off_ff, 16'd0, 32'd0));
                        end else begin
                           cacc_in   = {6'd0, b[3:0]};
                           fstart_in = off_ff;
                           phase_in  = PH_CODE1;
                        end
                     end
                  end
                  PH_CODE1, PH_CODE2: begin
                     if (!digit) begin
                        phase_in = PH_ERROR;
                        res = add_res(res, mk_res(KIND_ERR, off_ff, 16'd0, 32'd0));
                     end else begin
                        cacc_in  = 10'({cacc_ff, 3'd0} + {cacc_ff, 1'b0} + 13'(b[3:0]));
                        phase_in = (phase_ff == PH_CODE1) ? PH_CODE2 : PH_CODE_SP;
                     end
                  end
                  PH_CODE_SP: begin
                     if (b != " " || cacc_ff < 10'd100 || cacc_ff > 10'd600) begin
                        phase_in = PH_ERROR;
                        res = add_res(res, mk_res(KIND_ERR, off_ff, 16'd0, 32'd0));
                     end else begin
                        res = add_res(res, mk_res(KIND_CODE, fstart_ff, 16'd3,
                                                  {22'd0, cacc_ff}));
                        fstart_in = pos1[15:0];
                        phase_in  = PH_REASON;
                     end
                  end
                  PH_LINE_NL: begin
                     if (!nl) begin
                        if (b == ":" || b == " " || hcnt_ff >= HdrLimit) begin
                           phase_in = PH_IGNORE;
                        end else begin
                           fstart_in = off_ff;
                           lastns_in = off_ff;
                           match_in  = (lc == len_name_char(4'd0));
                           midx_in   = match_in ? 4'd1 : 4'd0;
                           phase_in  = PH_NAME;
                        end
                     end
                  end
                  PH_NAME: begin
                     if (b == ":" || b == " ") begin
                        phase_in = PH_NAME_DELIM;
                     end else begin
                        lastns_in = off_ff;
                        if (match_ff) begin
                           if (midx_ff < LEN_NAME_SIZE && lc == len_name_char(midx_ff))
                              midx_in = midx_ff + 4'd1;
                           else
                              match_in = 1'b0;
                        end
                     end
                  end
                  PH_NAME_DELIM: begin
                     if (nl) begin
                        phase_in = PH_LINE_NL;
                     end else if (!(b == ":" || b == " ")) begin
                        res = add_res(res, mk_res(KIND_NAME, fstart_ff,
                                                  lastns_ff - fstart_ff + 16'd1, 32'd0));
                        hcnt_in = hcnt_ff + 7'd1;
                        chosen  = match_ff && (midx_ff == LEN_NAME_SIZE) && !seen_ff;
                        if (chosen) begin
                           seen_in = 1'b1;
                           lacc_in = {28'd0, b[3:0]};
                        end
                        match_in  = chosen && digit;
                        if (!(chosen && digit)) lacc_in = chosen ? 32'd0 : lacc_ff;
                        fstart_in = off_ff;
                        lastns_in = off_ff;
                        phase_in  = PH_VALUE;
                     end
                  end
                  PH_VALUE: begin
                     if (nl) begin
                        res = add_res(res, mk_res(KIND_VALUE, fstart_ff,
                                                  lastns_ff - fstart_ff + 16'd1, 32'd0));
                        match_in = 1'b0;
                        phase_in = (hcnt_ff >= HdrLimit) ? PH_IGNORE : PH_LINE_NL;
                     end else begin
                        if (b != " ") lastns_in = off_ff;
                        if (match_ff) begin
                           if (!digit) begin
                              match_in = 1'b0;
                           end else begin
                              prod = {lacc_ff, 3'd0} + {3'd0, lacc_ff, 1'b0}
                                   + 36'(b[3:0]);
                              lacc_in = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                               : prod[31:0];
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // head terminator: LF LF or LF CR LF
            if (phase_in != PH_ERROR) begin
               head_end = (b == 8'h0A) && (term_ff == 2'd1 || term_ff == 2'd2);
               if (b == 8'h0A)                          term_in = 2'd1;
               else if (b == 8'h0D && term_ff == 2'd1)  term_in = 2'd2;
               else                                     term_in = 2'd0;
               if (head_end) begin
                  unique case (phase_in)
                     PH_WS, PH_METHOD, PH_METHOD_SP, PH_RPROTO, PH_RPROTO_SP,
                     PH_CODE1, PH_CODE2, PH_CODE_SP: begin
                        phase_in = PH_ERROR;
                        res = add_res(res, mk_res(KIND_ERR, off_ff, 16'd0, 32'd0));
                     end
                     PH_URI, PH_QUERY: begin
                        res = add_res(res, mk_res((phase_in == PH_URI) ? KIND_URI
                                                                       : KIND_QUERY,
                                                  fstart_in, pos1[15:0] - fstart_in,
                                                  32'd0));
                     end
                     default: begin
                     end
                  endcase
                  if (phase_in != PH_ERROR) begin
                     hlen_in = pos1;
                     res = add_res(res, mk_res(KIND_HEAD, 16'd0, sat16_32(lacc_in),
                                               {15'd0, pos1}));
                     if (lacc_in == 32'd0) begin
                        res = add_res(res, mk_res(KIND_MSG, sat16_17(pos1), 16'd0,
                                                  {15'd0, pos1}));
                        finished = 1'b1;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end
            end
         end else if ({16'd0, pos1} == ({16'd0, hlen_ff} + {1'b0, lacc_ff})) begin
            // last body byte
            res = add_res(res, mk_res(KIND_MSG, sat16_17(hlen_ff), sat16_32(lacc_ff),
                                      {15'd0, pos1}));
            finished = 1'b1;
         end

         // message wrap-up, length limit and buffer end
         if (finished) begin
            phase_in  = PH_WS;
            off_in    = 16'd0;
            fstart_in = 16'd0;
            lastns_in = 16'd0;
            hcnt_in   = 7'd0;
            midx_in   = 4'd0;
            match_in  = 1'b1;
            seen_in   = 1'b0;
            lacc_in   = 32'd0;
            cacc_in   = 10'd0;
            term_in   = 2'd0;
            hlen_in   = 17'd0;
         end else if (phase_in != PH_ERROR) begin
            if ({1'b0, off_ff} >= LastOff) begin
               phase_in = PH_ERROR;
               res = add_res(res, mk_res(KIND_ERR, off_ff, 16'd0, 32'd0));
            end else begin
               off_in = pos1[15:0];
               if (req_tlast)
                  res = add_res(res, mk_res(KIND_INCOMPLETE, 16'd0, 16'd0,
                                            {15'd0, pos1}));
            end
         end
      end

      if (res.count != 2'd0) res.item[res.count - 2'd1].last = 1'b1;
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         isreq_ff  <= 1'b1;
         phase_ff  <= PH_WS;
         off_ff    <= 16'd0;
         fstart_ff <= 16'd0;
         lastns_ff <= 16'd0;
         hcnt_ff   <= 7'd0;
         midx_ff   <= 4'd0;
         match_ff  <= 1'b1;
         seen_ff   <= 1'b0;
         lacc_ff   <= 32'd0;
         cacc_ff   <= 10'd0;
         term_ff   <= 2'd0;
         hlen_ff   <= 17'd0;
      end else begin
         if (csr_valid) isreq_ff <= csr_data;
         if (req_fire) begin
            phase_ff  <= phase_in;
            off_ff    <= off_in;
            fstart_ff <= fstart_in;
            lastns_ff <= lastns_in;
            hcnt_ff   <= hcnt_in;
            midx_ff   <= midx_in;
            match_ff  <= match_in;
            seen_ff   <= seen_in;
            lacc_ff   <= lacc_in;
            cacc_ff   <= cacc_in;
            term_ff   <= term_in;
            hlen_ff   <= hlen_in;
         end
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (res.count > 2'd0) fifo_ff[wr_ff]         <= res.item[0];
         if (res.count > 2'd1) fifo_ff[wr_ff + 2'd1]  <= res.item[1];
         if (res.count > 2'd2) fifo_ff[wr_ff + 2'd2]  <= res.item[2];
      end
   end

   // result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 2'd0;
         wr_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (pop) rd_ff <= rd_ff + 2'd1;
         if (req_fire) wr_ff <= wr_ff + res.count;
         cnt_ff <= cnt_ff + (req_fire ? {1'b0, res.count} : 3'd0) - {2'd0, pop};
      end
   end

endmodule
